// ===== rtl/ps2fr_pkg.sv =====
`default_nettype none
package ps2fr_pkg;

  // Action codes carried in the input tuser.
  localparam logic [1:0] ACT_EDGE       = 2'd0;
  localparam logic [1:0] ACT_ARM_ONE    = 2'd1;
  localparam logic [1:0] ACT_ARM_STREAM = 2'd2;
  localparam logic [1:0] ACT_DISARM     = 2'd3;

  // Receive modes.
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_ONESHOT = 2'd1;
  localparam logic [1:0] MODE_STREAM  = 2'd2;

  // Frame bit positions after the increment on each edge.
  localparam logic [3:0] POS_START     = 4'd1;
  localparam logic [3:0] POS_LAST_DATA = 4'd9;
  localparam logic [3:0] POS_PARITY    = 4'd10;

  // Error codes.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_START  = 2'd1;
  localparam logic [1:0] ERR_PARITY = 2'd2;
  localparam logic [1:0] ERR_STOP   = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic       data_bit;
    logic [3:0] packet_length;
  } item_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_value;
    logic        last_of_packet;
    logic [1:0]  fault_code;
    logic [15:0] packet_total;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/ps2fr_core.sv =====
`default_nettype none
module ps2fr_core
  import ps2fr_pkg::*;
#(
  parameter int MAX_PACKET = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    step,
  input  wire item_t   item,
  output result_t      result
);

  // Lengths arrive on a 4-bit field, so the cap never exceeds 15.
  localparam logic [3:0] LEN_CAP = (MAX_PACKET > 15) ? 4'd15 : 4'(MAX_PACKET);

  logic [3:0]  bit_pos_r,  bit_pos_nxt;
  logic [7:0]  shift_r,    shift_nxt;
  logic        parity_r,   parity_nxt;
  logic        bad_r,      bad_nxt;
  logic [1:0]  mode_r,     mode_nxt;
  logic [3:0]  len_r,      len_nxt;
  logic [3:0]  idx_r,      idx_nxt;
  logic [15:0] count_r,    count_nxt;

  logic [3:0]  pos_inc;
  logic [3:0]  idx_inc;
  logic [3:0]  len_clamped;
  logic [2:0]  data_sel;

  always_comb begin
    pos_inc  = bit_pos_r + 4'd1;
    idx_inc  = idx_r + 4'd1;
    data_sel = 3'(pos_inc - 4'd2);
    if (item.packet_length == 4'd0) begin
      len_clamped = 4'd1;
    end else if (item.packet_length > LEN_CAP) begin
      len_clamped = LEN_CAP;
    end else begin
      len_clamped = item.packet_length;
    end

    bit_pos_nxt = bit_pos_r;
    shift_nxt   = shift_r;
    parity_nxt  = parity_r;
    bad_nxt     = bad_r;
    mode_nxt    = mode_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;

    result.byte_valid     = 1'b0;
    result.byte_value     = 8'd0;
    result.last_of_packet = 1'b0;
    result.fault_code     = ERR_NONE;

    case (item.action)
      ACT_ARM_ONE: begin
        len_nxt  = len_clamped;
        mode_nxt = MODE_ONESHOT;
      end
      ACT_ARM_STREAM: begin
        len_nxt   = len_clamped;
        mode_nxt  = MODE_STREAM;
        count_nxt = 16'd0;
      end
      ACT_DISARM: begin
        mode_nxt = MODE_OFF;
      end
      default: begin
        if (mode_r == MODE_OFF) begin
          bit_pos_nxt = 4'd0;
        end else if (pos_inc <= POS_START) begin
          if (item.data_bit) begin
            result.fault_code = ERR_START;
            bit_pos_nxt       = 4'd0;
          end else begin
            bit_pos_nxt = POS_START;
            shift_nxt   = 8'd0;
            parity_nxt  = 1'b1;
            bad_nxt     = 1'b0;
          end
        end else if (pos_inc <= POS_LAST_DATA) begin
          bit_pos_nxt          = pos_inc;
          shift_nxt[data_sel]  = shift_r[data_sel] | item.data_bit;
          parity_nxt           = parity_r ^ item.data_bit;
        end else if (pos_inc == POS_PARITY) begin
          bit_pos_nxt = pos_inc;
          if (parity_r != item.data_bit) begin
            bad_nxt           = 1'b1;
            result.fault_code = ERR_PARITY;
          end
        end else begin
          // Stop bit: a good byte is delivered only with clean parity.
          bit_pos_nxt = 4'd0;
          if (!item.data_bit) begin
            result.fault_code = ERR_STOP;
          end else if (!bad_r) begin
            result.byte_valid = 1'b1;
            result.byte_value = shift_r;
            idx_nxt           = idx_inc;
            if (idx_inc >= len_r) begin
              idx_nxt               = 4'd0;
              result.last_of_packet = 1'b1;
              count_nxt             = count_r + 16'd1;
              if (mode_r != MODE_STREAM) begin
                mode_nxt = MODE_OFF;
              end
            end
          end
        end
      end
    endcase

    result.packet_total = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_pos_r <= 4'd0;
      shift_r   <= 8'd0;
      parity_r  <= 1'b1;
      bad_r     <= 1'b0;
      mode_r    <= MODE_OFF;
      len_r     <= 4'd0;
      idx_r     <= 4'd0;
      count_r   <= 16'd0;
    end else if (step) begin
      bit_pos_r <= bit_pos_nxt;
      shift_r   <= shift_nxt;
      parity_r  <= parity_nxt;
      bad_r     <= bad_nxt;
      mode_r    <= mode_nxt;
      len_r     <= len_nxt;
      idx_r     <= idx_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ps2_frame_receiver_packetizer_unit.sv =====
// Path: an accepted input beat goes to the input register, then is decoded into
// the output register.
// Throughput: one beat per cycle while the output is not stalled.
// Reset: synchronous, active low; clears the valid flags and the receiver
// state (disarmed, bit position, byte index and packet count at zero).
`default_nettype none
module ps2_frame_receiver_packetizer_unit
  import ps2fr_pkg::*;
#(
  parameter int MAX_PACKET = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [0] data_bit, [4:1] packet_length, [7:5] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] byte_value, [23:8] packet_total
  output logic [2:0]       out_tuser,  // [0] byte_valid, [2:1] fault_code
  output logic             out_tlast   // last_of_packet
);

  logic    stage_valid_r;
  item_t   stage_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t core_res;
  logic    out_free;
  logic    advance;

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = stage_valid_r && out_free;
  assign in_tready = !stage_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_tready) begin
      stage_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stage_item_r.action        <= in_tuser;
      stage_item_r.data_bit      <= in_tdata[0];
      stage_item_r.packet_length <= in_tdata[4:1];
    end
  end

  ps2fr_core #(
    .MAX_PACKET(MAX_PACKET)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_item_r),
    .result (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.packet_total, out_res_r.byte_value};
  assign out_tuser  = {out_res_r.fault_code, out_res_r.byte_valid};
  assign out_tlast  = out_res_r.last_of_packet;

endmodule
`default_nettype wire

// ===== rtl/ps2fr_checker.sv =====
`default_nettype none
module ps2fr_checker
  import ps2fr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // Only a delivered byte can close a packet.
  a_last_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("packet end without a byte");

  // A delivered byte never carries an error.
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ERR_NONE)
    else $error("byte delivered with an error code");

  // Without a byte the byte field reads zero.
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[7:0] == 8'd0)
    else $error("byte field set without a byte");

endmodule

bind ps2_frame_receiver_packetizer_unit ps2fr_checker u_ps2fr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== sim/ps2_frame_receiver_packetizer_unit_test.sv =====
`timescale 1ns / 1ps
module ps2_frame_receiver_packetizer_unit_test;
  import ps2fr_pkg::*;

  localparam int MAX_PKT = 8;
  localparam int LATENCY = 2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 440;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  ps2_frame_receiver_packetizer_unit #(.MAX_PACKET(MAX_PKT)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Shadow copy of the receiver state.
  logic [3:0]  bit_pos;
  logic [7:0]  shreg;
  logic        par_acc;
  logic        par_bad;
  logic [1:0]  rx_mode;
  logic [3:0]  arm_len;
  logic [7:0]  byte_idx;
  logic [15:0] pkt_count;

  beat_t   frame_q[$];
  beat_t   dir_tab[$];
  result_t pending_results[$];
  beat_t   cur;
  result_t want;
  result_t got;

  int idle_pct;
  int stall_pct;
  int errors;
  int cycles;
  int n_in;
  int n_out;
  int n_bytes;
  int n_last;
  int n_err[4];
  int ph;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t receive_step(item_t it);
    result_t    r;
    logic [3:0] len;
    r = '0;
    if (it.packet_length == 4'd0) len = 4'd1;
    else if (it.packet_length > MAX_PKT) len = 4'(MAX_PKT);
    else len = it.packet_length;
    case (it.action)
      ACT_ARM_ONE: begin
        arm_len = len;
        rx_mode = MODE_ONESHOT;
      end
      ACT_ARM_STREAM: begin
        arm_len = len;
        rx_mode = MODE_STREAM;
        pkt_count = 16'd0;
      end
      ACT_DISARM: rx_mode = MODE_OFF;
      default: begin
        if (rx_mode == MODE_OFF) begin
          bit_pos = 4'd0;
        end else begin
          bit_pos = bit_pos + 4'd1;
          if (bit_pos <= POS_START) begin
            bit_pos = POS_START;
            if (it.data_bit) begin
              r.fault_code = ERR_START;
              bit_pos = 4'd0;
            end else begin
              shreg = 8'd0;
              par_acc = 1'b1;
              par_bad = 1'b0;
            end
          end else if (bit_pos <= POS_LAST_DATA) begin
            shreg = shreg | (8'(it.data_bit) << (bit_pos - 4'd2));
            par_acc = par_acc ^ it.data_bit;
          end else if (bit_pos == POS_PARITY) begin
            if (par_acc != it.data_bit) begin
              par_bad = 1'b1;
              r.fault_code = ERR_PARITY;
            end
          end else begin
            bit_pos = 4'd0;
            if (!it.data_bit) begin
              r.fault_code = ERR_STOP;
            end else if (!par_bad) begin
              r.byte_valid = 1'b1;
              r.byte_value = shreg;
              byte_idx = byte_idx + 8'd1;
              // A shorter length armed mid-packet closes the packet at the next delivered byte.
              if (byte_idx >= 8'(arm_len)) begin
                byte_idx = 8'd0;
                r.last_of_packet = 1'b1;
                pkt_count = pkt_count + 16'd1;
                if (rx_mode != MODE_STREAM) rx_mode = MODE_OFF;
              end
            end
          end
        end
      end
    endcase
    r.packet_total = pkt_count;
    return r;
  endfunction

  function automatic result_t rs(logic v, logic [7:0] val, logic lst, logic [1:0] err,
                                 logic [15:0] tot);
    result_t r;
    r.byte_valid = v;
    r.byte_value = val;
    r.last_of_packet = lst;
    r.fault_code = err;
    r.packet_total = tot;
    return r;
  endfunction

  function automatic beat_t mk(logic [1:0] act, logic b, logic [3:0] len, bit typed,
                               result_t w);
    beat_t e;
    e.it.action = act;
    e.it.data_bit = b;
    e.it.packet_length = len;
    e.typed = typed;
    e.want = w;
    return e;
  endfunction

  task automatic feed(logic [1:0] act, logic b, logic [3:0] len);
    frame_q.push_back(mk(act, b, len, 1'b0, '0));
  endtask

  // The idle line is high: a run of ones lands every bit position on a rejected
  // start bit, which brings the receiver back to the frame boundary.
  task automatic idle_ones();
    int k;
    for (k = 0; k < 12; k++) feed(ACT_EDGE, 1'b1, 4'($urandom_range(15)));
  endtask

  task automatic gen_traffic(int n);
    int         made;
    int         r;
    int         k;
    int         cnt;
    logic [7:0] b;
    logic       sb;
    logic       pb;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        feed(ACT_DISARM, 1'($urandom_range(1)), 4'($urandom_range(15)));
        made++;
      end else if (r < 14) begin
        cnt = $urandom_range(1, 5);
        for (k = 0; k < cnt; k++)
          feed(ACT_EDGE, 1'($urandom_range(1)), 4'($urandom_range(15)));
        idle_ones();
        made += cnt + 12;
      end else begin
        if ($urandom_range(99) < 35) begin
          feed($urandom_range(1) ? ACT_ARM_STREAM : ACT_ARM_ONE, 1'($urandom_range(1)),
               4'($urandom_range(15)));
          made++;
        end
        b = 8'($urandom_range(255));
        sb = ($urandom_range(99) < 4);
        pb = ~^b;
        if ($urandom_range(99) < 8) pb = ~pb;
        feed(ACT_EDGE, sb, 4'($urandom_range(15)));
        for (k = 0; k < 8; k++) feed(ACT_EDGE, b[k], 4'($urandom_range(15)));
        feed(ACT_EDGE, pb, 4'($urandom_range(15)));
        feed(ACT_EDGE, ($urandom_range(99) >= 6), 4'($urandom_range(15)));
        made += 11;
        if (sb) begin
          idle_ones();
          made += 12;
        end
      end
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Result checking first, then the input side, in one process so that a beat
  // accepted at an edge is predicted before anything else happens at that edge.
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= stall_pct);
      if (out_tvalid && out_tready) begin
        n_out++;
        if (pending_results.size() == 0) begin
          $error("result beat with no expected result waiting");
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("byte_valid", want.byte_valid, out_tuser[0]);
          check_field("byte_value", want.byte_value, out_tdata[7:0]);
          check_field("last_of_packet", want.last_of_packet, out_tlast);
          check_field("fault_code", want.fault_code, out_tuser[2:1]);
          check_field("packet_total", want.packet_total, out_tdata[23:8]);
        end
        if (out_tuser[0]) n_bytes++;
        if (out_tlast) n_last++;
        n_err[out_tuser[2:1]]++;
      end
      if (in_tvalid && in_tready) begin
        cur = frame_q.pop_front();
        got = receive_step(cur.it);
        pending_results.push_back(cur.typed ? cur.want : got);
        n_in++;
      end
      if (in_tvalid && !in_tready) begin
        // Hold the beat until it is taken.
      end else if (frame_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, frame_q[0].it.packet_length, frame_q[0].it.data_bit};
        in_tuser  <= frame_q[0].it.action;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[ps2_frame_receiver_packetizer_unit] ERROR");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tuser = ACT_EDGE;
    out_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    errors = 0;
    cycles = 0;
    n_in = 0;
    n_out = 0;
    n_bytes = 0;
    n_last = 0;
    n_err = '{0, 0, 0, 0};
    bit_pos = 4'd0;
    shreg = 8'd0;
    par_acc = 1'b1;
    par_bad = 1'b0;
    rx_mode = MODE_OFF;
    arm_len = 4'd0;
    byte_idx = 8'd0;
    pkt_count = 16'd0;

    // Edge while disarmed, one-shot arm with a zero length, a high start bit,
    // then a 0xFF frame that fills the one-byte packet.
    dir_tab.push_back(mk(ACT_EDGE, 1'b1, 4'd0, 1'b1, rs(1'b0, 8'h00, 1'b0, ERR_NONE, 16'd0)));
    dir_tab.push_back(mk(ACT_ARM_ONE, 1'b0, 4'd0, 1'b1, rs(1'b0, 8'h00, 1'b0, ERR_NONE, 16'd0)));
    dir_tab.push_back(mk(ACT_EDGE, 1'b1, 4'd0, 1'b1, rs(1'b0, 8'h00, 1'b0, ERR_START, 16'd0)));
    dir_tab.push_back(mk(ACT_EDGE, 1'b0, 4'd15, 1'b0, '0));
    for (ph = 0; ph < 8; ph++) dir_tab.push_back(mk(ACT_EDGE, 1'b1, 4'd15, 1'b0, '0));
    dir_tab.push_back(mk(ACT_EDGE, 1'b1, 4'd0, 1'b0, '0));
    dir_tab.push_back(mk(ACT_EDGE, 1'b1, 4'd0, 1'b1, rs(1'b1, 8'hFF, 1'b1, ERR_NONE, 16'd1)));
    // Stream arm with an oversized length clears the count; a zero byte with
    // wrong parity and a low stop bit follows.
    dir_tab.push_back(mk(ACT_ARM_STREAM, 1'b0, 4'd15, 1'b1,
                         rs(1'b0, 8'h00, 1'b0, ERR_NONE, 16'd0)));
    for (ph = 0; ph < 9; ph++) dir_tab.push_back(mk(ACT_EDGE, 1'b0, 4'd8, 1'b0, '0));
    dir_tab.push_back(mk(ACT_EDGE, 1'b0, 4'd1, 1'b1, rs(1'b0, 8'h00, 1'b0, ERR_PARITY, 16'd0)));
    dir_tab.push_back(mk(ACT_EDGE, 1'b0, 4'd1, 1'b1, rs(1'b0, 8'h00, 1'b0, ERR_STOP, 16'd0)));
    dir_tab.push_back(mk(ACT_DISARM, 1'b1, 4'd8, 1'b1, rs(1'b0, 8'h00, 1'b0, ERR_NONE, 16'd0)));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 25; stall_pct = 25; end
      endcase
      if (ph == 0) begin
        foreach (dir_tab[i]) frame_q.push_back(dir_tab[i]);
      end
      gen_traffic(ITEMS_PER_PHASE);
      while (frame_q.size() != 0) @(posedge clk);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d beats over four pacing phases; checked %0d results with %0d bytes,",
             n_in, n_out, n_bytes);
    $display("%0d packet ends and %0d/%0d/%0d start/parity/stop errors.",
             n_last, n_err[ERR_START], n_err[ERR_PARITY], n_err[ERR_STOP]);
    if (errors == 0) begin
      $display("[ps2_frame_receiver_packetizer_unit] OK");
    end else begin
      $display("[ps2_frame_receiver_packetizer_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ps2fr_pkg.sv
rtl/ps2fr_core.sv
rtl/ps2_frame_receiver_packetizer_unit.sv
rtl/ps2fr_checker.sv
sim/ps2_frame_receiver_packetizer_unit_test.sv
